>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg: shared definitions of the bitmap page allocator
// Operation and status codes, fixed field widths and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// fixed field widths
	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 16;
	localparam int NUM_W    = 16;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 17;

	// map sizing: 4096-byte pages, eight bits to a byte
	localparam int PAGE_SHIFT = 12;
	localparam int BYTE_SHIFT = 3;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOINIT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic                accept;       // latch page index and its word split
		logic                init_start;   // latch clamped count and reservation
		logic                init_step;    // write one map word of the rebuild
		logic                init_finish;  // arm the map, load the result
		logic                alloc_rd;     // read the word at the search hint
		logic                hint_inc;     // advance the hint, read the next word
		logic                alloc_commit; // clear the lowest free bit, load result
		logic                free_rd;      // read the word that holds the page
		logic                free_commit;  // set the page bit, load result
		logic                plain_load;   // load a result with no map change
		logic [STATUS_W-1:0] plain_status;
	} bpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ready;      // map has been initialized
		logic none_free;  // free page count is zero
		logic in_range;   // latched page index is below the map size
		logic word_zero;  // read word has no free page
		logic sweep_last; // rebuild is at the last map word
	} bpa_sts_t;

endpackage

>>> rtl/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram: simple dual-port RAM
// One write port and one read port with registered read data; the read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl: allocator controller
// Takes one word at a time, sequences the map reads and writes of each
// operation and owns the valid bit of the output register.
// ----------------------------------------------------------------------------
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	output logic              out_valid,
	input  logic              out_stall,
	output bpa_cmd_t          cmd,
	input  bpa_sts_t          sts
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_ALLOC     = 3'd1;
	localparam logic [2:0] S_ALLOC_CHK = 3'd2;
	localparam logic [2:0] S_FREE      = 3'd3;
	localparam logic [2:0] S_FREE_CHK  = 3'd4;
	localparam logic [2:0] S_INIT      = 3'd5;
	localparam logic [2:0] S_INIT_END  = 3'd6;
	localparam logic [2:0] S_PLAIN     = 3'd7;

	logic [2:0]          state_q, state_d;
	logic [STATUS_W-1:0] code_q, code_d;
	logic                out_valid_q;
	logic                slot_free;
	logic                load;

	// output slot is free when empty or being taken this cycle
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = cmd.free_commit || cmd.alloc_commit || cmd.init_finish ||
		cmd.plain_load;

	// sequence the operation
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.plain_status = code_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (func)
						FUNC_ALLOC: state_d = S_ALLOC;
						FUNC_FREE:  state_d = S_FREE;
						FUNC_INIT: begin
							cmd.init_start = 1'b1;
							state_d        = S_INIT;
						end
						default: begin
							code_d  = ST_OK;
							state_d = S_PLAIN;
						end
					endcase
				end
			end
			S_ALLOC: begin
				if (!sts.ready) begin
					code_d  = ST_NOINIT;
					state_d = S_PLAIN;
				end else if (sts.none_free) begin
					code_d  = ST_NONE;
					state_d = S_PLAIN;
				end else begin
					cmd.alloc_rd = 1'b1;
					state_d      = S_ALLOC_CHK;
				end
			end
			S_ALLOC_CHK: begin
				if (sts.word_zero) begin
					cmd.hint_inc = 1'b1;
				end else if (slot_free) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_FREE: begin
				if (!sts.ready) begin
					code_d  = ST_NOINIT;
					state_d = S_PLAIN;
				end else if (!sts.in_range) begin
					code_d  = ST_RANGE;
					state_d = S_PLAIN;
				end else begin
					cmd.free_rd = 1'b1;
					state_d     = S_FREE_CHK;
				end
			end
			S_FREE_CHK: begin
				if (slot_free) begin
					cmd.free_commit = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_INIT_END;
				end
			end
			S_INIT_END: begin
				if (slot_free) begin
					cmd.init_finish = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_PLAIN: begin
				if (slot_free) begin
					cmd.plain_load = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, plain result code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			code_q      <= code_d;
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	// a result never overwrites one that is still waiting
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("result loaded over a waiting word");

	// at most one result source per cycle
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.free_commit, cmd.alloc_commit, cmd.init_finish, cmd.plain_load}))
		else $error("more than one result source");

	// an accepted word always starts an operation
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted word dropped");

	// allocation searches only a ready map with free pages
	a_alloc_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_rd |-> (sts.ready && !sts.none_free))
		else $error("search started without free pages");

	// allocation commits only on a word that holds a free page
	a_alloc_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_commit |-> !sts.word_zero)
		else $error("allocation from an empty word");

endmodule

>>> rtl/bpa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_dpath: allocator datapath
// Holds the free map RAM, the free count, the search hint, the page count
// register and the output register.
// ----------------------------------------------------------------------------
module bpa_dpath
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = 65536,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_data,
	input  logic [IDX_W-1:0]    page_index,
	output logic [NUM_W-1:0]    page_number,
	output logic [STATUS_W-1:0] status,
	output logic [CNT_W-1:0]    free_pages,
	input  bpa_cmd_t            cmd,
	output bpa_sts_t            sts
);

	localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int PW        = $clog2(MAX_PAGES + 1);
	localparam int CMPW      = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
	localparam int KW        = (CMPW > IDX_W) ? CMPW : IDX_W;
	localparam int NW        = (PW > CNT_W) ? PW : CNT_W;
	// page index to word index by reciprocal multiply, exact for all indexes
	localparam int     SH    = IDX_W + BW;
	localparam int     MW    = IDX_W + 2;
	localparam int     PRW   = IDX_W + MW;
	localparam longint RECIP = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;

	logic [CNT_W-1:0]     page_count_q;
	logic                 map_ready_q;
	logic [PW-1:0]        free_total_q;
	logic [PW-1:0]        map_pages_q;
	logic [AW-1:0]        hint_q;
	logic [IDX_W-1:0]     idx_q;
	logic [AW-1:0]        widx_q;
	logic [PW-1:0]        n_q;
	logic [PW-1:0]        r_q;
	logic [CMPW-1:0]      base_q;
	logic [AW-1:0]        wcnt_q;

	logic [PRW-1:0]       prod;
	logic [NW-1:0]        n_wide;
	logic [PW-1:0]        n_clamp;
	logic [PW:0]          rsv;
	logic [PW-1:0]        r_clamp;
	logic [KW-1:0]        bit_wide;
	logic [BW-1:0]        free_bit;
	logic [BW-1:0]        low_bit;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] sweep_word;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_waddr;
	logic [AW-1:0]        ram_raddr;
	logic                 ram_we;
	logic                 ram_re;
	logic                 dbl;
	logic [CMPW-1:0]      alloc_page;

	// split the incoming page index into map word and bit
	assign prod     = PRW'(page_index) * PRW'(RECIP);
	assign bit_wide = KW'(idx_q) - KW'(widx_q) * KW'(WORD_BITS);
	assign free_bit = bit_wide[BW-1:0];
	assign dbl      = rd_data[free_bit];

	// clamp the page count and size the map's own reservation
	assign n_wide  = NW'(page_count_q);
	assign n_clamp = (n_wide > NW'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(n_wide);
	assign rsv     = (PW+1)'(1) +
		(((PW+1)'(1) + (PW+1)'(n_clamp >> BYTE_SHIFT)) >> PAGE_SHIFT);
	assign r_clamp = (rsv < (PW+1)'(n_clamp)) ? PW'(rsv) : n_clamp;

	// rebuild word: pages from the reservation up to the count are free
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			sweep_word[i] = ((base_q + CMPW'(i)) >= CMPW'(r_q)) &&
				((base_q + CMPW'(i)) < CMPW'(n_q));
		end
	end

	// find the lowest free page of the read word
	always_comb begin
		low_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (rd_data[i]) begin
				low_bit = BW'(i);
			end
		end
	end
	assign alloc_page = CMPW'(hint_q) * CMPW'(WORD_BITS) + CMPW'(low_bit);

	// map port steering
	assign ram_re    = cmd.alloc_rd || cmd.hint_inc || cmd.free_rd;
	assign ram_raddr = cmd.hint_inc ? (hint_q + AW'(1)) : (cmd.free_rd ? widx_q : hint_q);
	assign ram_we    = cmd.init_step || cmd.alloc_commit || (cmd.free_commit && !dbl);
	always_comb begin
		if (cmd.init_step) begin
			ram_waddr = wcnt_q;
			ram_wdata = sweep_word;
		end else if (cmd.free_commit) begin
			ram_waddr = widx_q;
			ram_wdata = rd_data | (WORD_BITS'(1) << free_bit);
		end else begin
			ram_waddr = hint_q;
			ram_wdata = rd_data & (rd_data - WORD_BITS'(1));
		end
	end

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// status toward the controller
	assign sts.ready      = map_ready_q;
	assign sts.none_free  = (free_total_q == '0);
	assign sts.in_range   = (KW'(idx_q) < KW'(map_pages_q));
	assign sts.word_zero  = (rd_data == '0);
	assign sts.sweep_last = (wcnt_q == AW'(MAP_WORDS - 1));

	// map state: config register, ready flag, counts and search hint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= '0;
			map_ready_q  <= 1'b0;
			free_total_q <= '0;
			map_pages_q  <= '0;
			hint_q       <= '0;
			wcnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				page_count_q <= cfg_data;
			end
			if (cmd.init_start) begin
				wcnt_q <= '0;
			end else if (cmd.init_step) begin
				wcnt_q <= wcnt_q + AW'(1);
			end
			if (cmd.init_finish) begin
				map_ready_q  <= 1'b1;
				map_pages_q  <= n_q;
				free_total_q <= n_q - r_q;
				hint_q       <= '0;
			end else if (cmd.hint_inc) begin
				hint_q <= hint_q + AW'(1);
			end else if (cmd.alloc_commit) begin
				free_total_q <= free_total_q - PW'(1);
			end else if (cmd.free_commit && !dbl) begin
				free_total_q <= free_total_q + PW'(1);
				if (widx_q < hint_q) begin
					hint_q <= widx_q;
				end
			end
		end
	end

	// operation operands and rebuild position
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q  <= page_index;
			widx_q <= AW'(prod >> SH);
		end
		if (cmd.init_start) begin
			n_q    <= n_clamp;
			r_q    <= r_clamp;
			base_q <= '0;
		end else if (cmd.init_step) begin
			base_q <= base_q + CMPW'(WORD_BITS);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.alloc_commit) begin
			page_number <= NUM_W'(alloc_page);
			status      <= ST_OK;
			free_pages  <= CNT_W'(free_total_q - PW'(1));
		end else if (cmd.free_commit) begin
			page_number <= '0;
			status      <= dbl ? ST_DOUBLE : ST_OK;
			free_pages  <= dbl ? CNT_W'(free_total_q) : CNT_W'(free_total_q + PW'(1));
		end else if (cmd.init_finish) begin
			page_number <= '0;
			status      <= ST_OK;
			free_pages  <= CNT_W'(n_q - r_q);
		end else if (cmd.plain_load) begin
			page_number <= '0;
			status      <= cmd.plain_status;
			free_pages  <= CNT_W'(free_total_q);
		end
	end

endmodule

>>> rtl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator: first-fit page frame allocator on a free bitmap
// Input words carry func (allocate, free, initialize, no-op) and page_index;
// each gives one output word of page_number, status and free_pages. Both
// channels use valid/stall; cfg_we writes page_count, read at the next init.
// One word is in work at a time; a new one is taken while the previous
// result still waits in the output register.
// From accept, a no-op loads its result in the plain result state, and a
// failed check goes on to that state; a free reads the page's map word, then
// commits; allocate reads the word at the search hint and advances past each
// fully used map word; initialize writes one map word a cycle through the
// single RAM write port. The next input word is taken at the same edge at
// which the result can first be taken, so accepted words follow results.
// Reset clears the ready flag, free count and page count; the map RAM
// itself is not cleared and is rebuilt by initialize before any use.
// A stalled result holds in the output register and the block stops
// before its next commit until the result is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = 65536,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [IDX_W-1:0]    page_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [NUM_W-1:0]    page_number,
	output logic [STATUS_W-1:0] status,
	output logic [CNT_W-1:0]    free_pages
);

	bpa_cmd_t cmd;
	bpa_sts_t sts;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	bpa_dpath #(
		.MAX_PAGES(MAX_PAGES),
		.WORD_BITS(WORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.page_index  (page_index),
		.page_number (page_number),
		.status      (status),
		.free_pages  (free_pages),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
